>>> hw/rtl/rvrm_pkg.sv
// Shared constants, types and arithmetic helpers for the rotation vector to matrix unit.
`default_nettype none
package rvrm_pkg;

	// field widths
	localparam int VW        = 32;
	localparam int NCOMP     = 3;
	localparam int NENT      = 9;
	localparam int THRESH_W  = 29;
	localparam int XW        = 68;

	// pipeline shape
	localparam int SQRT_BITS = 32;
	localparam int DIV_BITS  = 31;
	localparam int SIN_TERMS = 7;
	localparam int COS_TERMS = 8;
	localparam int PIPE_LAT  = 71;

	typedef logic signed [XW-1:0] wide_t;

	// Q1.30 / Q.30 constants
	localparam wide_t       ONE_Q30         = 68'sd1073741824;
	localparam logic [33:0] PI_Q30          = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30     = 34'd1686629713;
	localparam logic [33:0] TWO_PI_Q30      = 34'd6746518852;
	localparam logic [33:0] TWO_PI_LESS_HPI = 34'd5059889139;

	// register map
	localparam logic [THRESH_W-1:0] THRESH_RESET = 29'd268;
	localparam logic                REG_THRESH   = 1'b0;

	// magnitude of a signed component
	function automatic logic [VW-1:0] mag32(input logic signed [VW-1:0] x);
		logic [VW-1:0] m;
		m = x[VW-1] ? VW'(-x) : VW'(x);
		return m;
	endfunction

	// x / 2^sh rounded to nearest, ties away from zero
	function automatic wide_t rnd_shift(input wide_t x, input int unsigned sh);
		logic [XW-1:0] m;
		logic [XW-1:0] q;
		m = x[XW-1] ? XW'(-x) : XW'(x);
		q = (m + (68'd1 << (sh - 1))) >> sh;
		return x[XW-1] ? -$signed(q) : $signed(q);
	endfunction

	// clamp to signed 32 bits
	function automatic logic [VW-1:0] sat32(input wide_t x);
		logic [VW-1:0] r;
		if (x > 68'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -68'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[VW-1:0];
		end
		return r;
	endfunction

	// Horner divisors, innermost (highest-order) term first
	function automatic int sin_div(input int k);
		int n;
		n = SIN_TERMS - k;
		return 2 * n * (2 * n + 1);
	endfunction

	function automatic int cos_div(input int k);
		int n;
		n = COS_TERMS - k;
		return (2 * n - 1) * 2 * n;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rvrm_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
`default_nettype none
module rvrm_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] line_q [N];

	// shift one place per advance
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule
`default_nettype wire

>>> hw/rtl/rvrm_sqrt_cell.sv
// One result bit of the pipelined integer square root.
`default_nettype none
module rvrm_sqrt_cell #(
	parameter int BIT = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] rem_i,
	input  wire logic [31:0] root_i,
	output logic      [63:0] rem_s1,
	output logic      [31:0] root_s1
);

	logic [65:0] trial;

	// (root + 2^BIT)^2 - root^2
	assign trial = ({34'b0, root_i} << (BIT + 1)) + (66'd1 << (2 * BIT));

	always_ff @(posedge clk) begin
		if (en) begin
			if ({2'b0, rem_i} >= trial) begin
				rem_s1  <= rem_i - trial[63:0];
				root_s1 <= root_i | (32'd1 << BIT);
			end else begin
				rem_s1  <= rem_i;
				root_s1 <= root_i;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rvrm_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module rvrm_div_cell #(
	parameter int BIT = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [61:0] rem_i,
	input  wire logic [30:0] quo_i,
	input  wire logic [31:0] den_i,
	output logic      [61:0] rem_s1,
	output logic      [30:0] quo_s1,
	output logic      [31:0] den_s1
);

	logic [62:0] dsh;

	assign dsh = {31'b0, den_i} << BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= den_i;
			if ({1'b0, rem_i} >= dsh) begin
				rem_s1 <= rem_i - dsh[61:0];
				quo_s1 <= quo_i | (31'd1 << BIT);
			end else begin
				rem_s1 <= rem_i;
				quo_s1 <= quo_i;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rvrm_trig_cell.sv
// One Horner step a' = 1 - RND(r2*a / (D*2^30)) of the sine or cosine series, three stages.
`default_nettype none
module rvrm_trig_cell #(
	parameter int D = 2
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] r2_i,
	input  wire logic signed [31:0] a_i,
	output logic             [31:0] r2_s3,
	output logic signed      [31:0] a_s3
);

	localparam logic [63:0] HALF_D = 64'(D) << 29;
	localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / D);
	localparam logic [39:0] DIVW   = 40'(D);

	logic signed [64:0] p_s1;
	logic        [31:0] r2_s1;
	logic        [31:0] x_s2;
	logic        [31:0] q0_s2;
	logic               neg_s2;
	logic        [31:0] r2_s2;

	logic [64:0] pmag;
	logic [63:0] xsum;
	logic [31:0] xval;
	logic [63:0] xr;
	logic [39:0] qd;
	logic [39:0] rem;
	logic [32:0] q;
	logic [32:0] anext;

	// stage 1: product
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= $signed({1'b0, r2_i}) * a_i;
			r2_s1 <= r2_i;
		end
	end

	// stage 2: round to 2^30 and estimate quotient by reciprocal
	assign pmag = p_s1[64] ? 65'(-p_s1) : 65'(p_s1);
	assign xsum = pmag[63:0] + HALF_D;
	assign xval = xsum[61:30];
	assign xr   = 64'(xval) * 64'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= xval;
			q0_s2  <= xr[63:32];
			neg_s2 <= p_s1[64];
			r2_s2  <= r2_s1;
		end
	end

	// stage 3: one correction step, then subtract from one
	assign qd    = 40'(q0_s2) * DIVW;
	assign rem   = 40'(x_s2) - qd;
	assign q     = 33'(q0_s2) + ((rem >= DIVW) ? 33'd1 : 33'd0);
	assign anext = neg_s2 ? 33'd1073741824 + q : 33'd1073741824 - q;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= $signed(anext[31:0]);
			r2_s3 <= r2_s2;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rotation_vector_to_rotation_matrix_unit.sv
// Rotation vector to rotation matrix (SO(3) exponential map), fully pipelined.
// Throughput: one word per cycle while the skid is empty; every cell registers its own step, so no stage is reused.
// A two-entry output register/skid lets input flow while one result waits.
// Reset (arst_n low) clears all valid bits and the skid; threshold returns to 268.
`default_nettype none
module rotation_vector_to_rotation_matrix_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,  // rot_x, rot_y, rot_z
	// output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [287:0] m_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

	localparam int VW  = rvrm_pkg::VW;
	localparam int NC  = rvrm_pkg::NCOMP;
	localparam int NE  = rvrm_pkg::NENT;
	localparam int LAT = rvrm_pkg::PIPE_LAT;
	localparam int SB  = rvrm_pkg::SQRT_BITS;
	localparam int DB  = rvrm_pkg::DIV_BITS;
	localparam int ST  = rvrm_pkg::SIN_TERMS;
	localparam int CT  = rvrm_pkg::COS_TERMS;

	// control
	logic                            adv;
	logic [LAT-1:0]                  vld_q;
	logic [rvrm_pkg::THRESH_W-1:0]   thr_q;
	logic                            out_v_q;
	logic [NE*VW-1:0]                out_d_q;
	logic                            skid_v_q;
	logic [NE*VW-1:0]                skid_d_q;

	// front end
	logic [NC*VW-1:0]  v_s1;
	logic [63:0]       sq_s1 [NC];
	logic [63:0]       n_s2;
	logic [NC*VW-1:0]  v_s34;
	logic [NC*VW-1:0]  v_s67;
	logic [NC*VW-1:0]  v_s68;

	// square root chain
	logic [63:0] srem  [SB+1];
	logic [31:0] sroot [SB+1];
	logic [31:0] theta;

	// divider chains
	logic [61:0] drem [NC][DB+1];
	logic [30:0] dquo [NC][DB+1];
	logic [31:0] dden [NC][DB+1];
	logic [NC:0] flags_s35;
	logic [NC:0] flags_s66;
	logic signed [31:0] u_s67 [NC];

	// angle reduction
	logic [33:0]        t_s35;
	logic [32:0]        t_s36;
	logic signed [31:0] r_s37;
	logic               neg_s37;
	logic signed [63:0] rr_s38;
	logic [31:0]        r2_s39;
	logic               small_s35;
	logic               small_s70;
	logic [33:0]        t4;
	logic [33:0]        t36n;
	logic [34:0]        rfold;
	logic               negf;
	logic [63:0]        r2sum;

	// series
	logic [31:0]        sr2 [ST+1];
	logic signed [31:0] sa  [ST+1];
	logic [31:0]        cr2 [CT+1];
	logic signed [31:0] ca  [CT+1];
	logic [31:0]        r_s60;
	logic               neg_s63;
	logic signed [63:0] ra_s61;
	logic signed [31:0] sn_s62;
	logic [31:0]        sn_s67;
	logic signed [33:0] omc_s64;
	logic [33:0]        omc_s69;
	logic signed [33:0] csg;

	// tail
	logic signed [63:0] uu_s68 [6];
	logic signed [63:0] su_s68 [NC];
	logic [63:0]        vsq_s68 [NC];
	logic signed [63:0] vp_s68 [NC];
	logic signed [33:0] kk_s69 [6];
	logic signed [33:0] ssu_s69 [NC];
	logic [VW-1:0]      sm_s69 [NE];
	logic signed [67:0] okk_s70 [6];
	logic signed [33:0] ssu_s70 [NC];
	logic [NE*VW-1:0]   sm_s70;
	logic [NE*VW-1:0]   res_s71;
	logic [NE*VW-1:0]   sm_pack_s69;
	logic signed [VW-1:0] vc68 [NC];
	logic signed [VW-1:0] vc67 [NC];
	logic signed [VW-1:0] vc34 [NC];
	logic signed [VW-1:0] vc0  [NC];

	// pipeline moves whenever the skid stage is free
	assign adv      = !skid_v_q;
	assign s_tready = adv;
	assign pready   = 1'b1;

	// APB register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rvrm_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == rvrm_pkg::REG_THRESH) begin
			thr_q <= pwdata[rvrm_pkg::THRESH_W-1:0];
		end
	end

	assign prdata = (paddr[2] == rvrm_pkg::REG_THRESH) ? 32'(thr_q) : 32'd0;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_comp
		assign vc0[c]  = $signed(s_tdata[c*VW +: VW]);
		assign vc34[c] = $signed(v_s34[c*VW +: VW]);
		assign vc67[c] = $signed(v_s67[c*VW +: VW]);
		assign vc68[c] = $signed(v_s68[c*VW +: VW]);
	end

	// stage 1: squares; stage 2: sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= s_tdata;
			for (int c = 0; c < NC; c++) begin
				sq_s1[c] <= 64'(rvrm_pkg::mag32(vc0[c])) * 64'(rvrm_pkg::mag32(vc0[c]));
			end
			n_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// square root: one cell per result bit
	assign srem[0]  = n_s2;
	assign sroot[0] = '0;
	for (genvar k = 0; k < SB; k++) begin : g_sqrt
		rvrm_sqrt_cell #(.BIT(SB - 1 - k)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(srem[k]), .root_i(sroot[k]),
			.rem_s1(srem[k+1]), .root_s1(sroot[k+1])
		);
	end
	assign theta = sroot[SB];

	rvrm_delay #(.W(NC*VW), .N(33)) u_dly_v1 (.clk(clk), .en(adv), .d(v_s1), .q(v_s34));
	rvrm_delay #(.W(NC*VW), .N(33)) u_dly_v2 (.clk(clk), .en(adv), .d(v_s34), .q(v_s67));

	// stage 35: divider setup, threshold compare, first reduction step
	assign t4 = {theta, 2'b00};
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NC; c++) begin
				drem[c][0]   <= {rvrm_pkg::mag32(vc34[c]), 30'b0} + 62'(theta[31:1]);
				dden[c][0]   <= theta;
				flags_s35[c] <= vc34[c][VW-1];
			end
			flags_s35[NC] <= (theta == 32'd0);
			small_s35     <= theta < 32'(thr_q);
			t_s35         <= (t4 >= rvrm_pkg::TWO_PI_Q30) ? t4 - rvrm_pkg::TWO_PI_Q30 : t4;
		end
	end

	// divider: one cell per quotient bit, per component
	for (genvar c = 0; c < NC; c++) begin : g_lane
		assign dquo[c][0] = '0;
		for (genvar k = 0; k < DB; k++) begin : g_div
			rvrm_div_cell #(.BIT(DB - 1 - k)) u_cell (
				.clk(clk), .en(adv),
				.rem_i(drem[c][k]), .quo_i(dquo[c][k]), .den_i(dden[c][k]),
				.rem_s1(drem[c][k+1]), .quo_s1(dquo[c][k+1]), .den_s1(dden[c][k+1])
			);
		end
	end

	rvrm_delay #(.W(NC+1), .N(31)) u_dly_flags (
		.clk(clk), .en(adv), .d(flags_s35), .q(flags_s66)
	);

	// stage 67: signed unit axis
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NC; c++) begin
				if (flags_s66[NC]) begin
					u_s67[c] <= '0;
				end else if (flags_s66[c]) begin
					u_s67[c] <= -$signed({1'b0, dquo[c][DB]});
				end else begin
					u_s67[c] <= $signed({1'b0, dquo[c][DB]});
				end
			end
		end
	end

	// stages 36..39: second reduction, fold to [-pi/2, pi/2], square
	assign t36n  = 34'(t_s36);
	assign negf  = (t36n > rvrm_pkg::HALF_PI_Q30) && (t36n < rvrm_pkg::TWO_PI_LESS_HPI);
	assign rfold = (t36n <= rvrm_pkg::HALF_PI_Q30) ? 35'(t36n) :
		(negf ? 35'(rvrm_pkg::PI_Q30) - 35'(t36n) : 35'(t36n) - 35'(rvrm_pkg::TWO_PI_Q30));
	assign r2sum = rr_s38 + 64'sd536870912;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s36   <= (t_s35 >= rvrm_pkg::TWO_PI_Q30) ? 33'(t_s35 - rvrm_pkg::TWO_PI_Q30)
				: 33'(t_s35);
			r_s37   <= $signed(rfold[31:0]);
			neg_s37 <= negf;
			rr_s38  <= r_s37 * r_s37;
			r2_s39  <= r2sum[61:30];
		end
	end

	// sine and cosine series: one cell per Horner term
	assign sr2[0] = r2_s39;
	assign sa[0]  = 32'sd1073741824;
	for (genvar k = 0; k < ST; k++) begin : g_sin
		rvrm_trig_cell #(.D(rvrm_pkg::sin_div(k))) u_cell (
			.clk(clk), .en(adv),
			.r2_i(sr2[k]), .a_i(sa[k]), .r2_s3(sr2[k+1]), .a_s3(sa[k+1])
		);
	end

	assign cr2[0] = r2_s39;
	assign ca[0]  = 32'sd1073741824;
	for (genvar k = 0; k < CT; k++) begin : g_cos
		rvrm_trig_cell #(.D(rvrm_pkg::cos_div(k))) u_cell (
			.clk(clk), .en(adv),
			.r2_i(cr2[k]), .a_i(ca[k]), .r2_s3(cr2[k+1]), .a_s3(ca[k+1])
		);
	end

	rvrm_delay #(.W(VW), .N(23)) u_dly_r (
		.clk(clk), .en(adv), .d(r_s37), .q(r_s60)
	);
	rvrm_delay #(.W(1), .N(26)) u_dly_neg (
		.clk(clk), .en(adv), .d(neg_s37), .q(neg_s63)
	);

	// stages 61..64: sine = r * series, 1 - cos
	assign csg = neg_s63 ? -34'(ca[CT]) : 34'(ca[CT]);
	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s61  <= $signed(r_s60) * sa[ST];
			sn_s62  <= 32'(rvrm_pkg::rnd_shift(68'(ra_s61), 30));
			omc_s64 <= 34'sd1073741824 - csg;
		end
	end

	rvrm_delay #(.W(VW), .N(5)) u_dly_sn (
		.clk(clk), .en(adv), .d(sn_s62), .q(sn_s67)
	);
	rvrm_delay #(.W(34), .N(5)) u_dly_omc (
		.clk(clk), .en(adv), .d(omc_s64), .q(omc_s69)
	);
	rvrm_delay #(.W(1), .N(35)) u_dly_small (
		.clk(clk), .en(adv), .d(small_s35), .q(small_s70)
	);

	// stage 68: products of axis, sine and raw vector
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s68     <= v_s67;
			uu_s68[0] <= u_s67[0] * u_s67[0];
			uu_s68[1] <= u_s67[1] * u_s67[1];
			uu_s68[2] <= u_s67[2] * u_s67[2];
			uu_s68[3] <= u_s67[0] * u_s67[1];
			uu_s68[4] <= u_s67[0] * u_s67[2];
			uu_s68[5] <= u_s67[1] * u_s67[2];
			for (int c = 0; c < NC; c++) begin
				su_s68[c]  <= $signed(sn_s67) * u_s67[c];
				vsq_s68[c] <= 64'(rvrm_pkg::mag32(vc67[c])) * 64'(rvrm_pkg::mag32(vc67[c]));
			end
			vp_s68[0] <= vc67[0] * vc67[1];
			vp_s68[1] <= vc67[0] * vc67[2];
			vp_s68[2] <= vc67[1] * vc67[2];
		end
	end

	// stage 69: rounding of Ku*Ku and sin*Ku; small-angle entries
	always_ff @(posedge clk) begin
		if (adv) begin
			kk_s69[0] <= 34'(rvrm_pkg::rnd_shift(-(68'(uu_s68[1]) + 68'(uu_s68[2])), 30));
			kk_s69[1] <= 34'(rvrm_pkg::rnd_shift(-(68'(uu_s68[0]) + 68'(uu_s68[2])), 30));
			kk_s69[2] <= 34'(rvrm_pkg::rnd_shift(-(68'(uu_s68[0]) + 68'(uu_s68[1])), 30));
			kk_s69[3] <= 34'(rvrm_pkg::rnd_shift(68'(uu_s68[3]), 30));
			kk_s69[4] <= 34'(rvrm_pkg::rnd_shift(68'(uu_s68[4]), 30));
			kk_s69[5] <= 34'(rvrm_pkg::rnd_shift(68'(uu_s68[5]), 30));
			for (int c = 0; c < NC; c++) begin
				ssu_s69[c] <= 34'(rvrm_pkg::rnd_shift(68'(su_s68[c]), 30));
			end
			sm_s69[0] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 -
				$signed((68'(vsq_s68[1]) + 68'(vsq_s68[2]) + 68'd67108864) >> 27));
			sm_s69[4] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 -
				$signed((68'(vsq_s68[0]) + 68'(vsq_s68[2]) + 68'd67108864) >> 27));
			sm_s69[8] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 -
				$signed((68'(vsq_s68[0]) + 68'(vsq_s68[1]) + 68'd67108864) >> 27));
			sm_s69[1] <= rvrm_pkg::sat32(-(68'(vc68[2]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[0]), 27));
			sm_s69[3] <= rvrm_pkg::sat32((68'(vc68[2]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[0]), 27));
			sm_s69[2] <= rvrm_pkg::sat32((68'(vc68[1]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[1]), 27));
			sm_s69[6] <= rvrm_pkg::sat32(-(68'(vc68[1]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[1]), 27));
			sm_s69[5] <= rvrm_pkg::sat32(-(68'(vc68[0]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[2]), 27));
			sm_s69[7] <= rvrm_pkg::sat32((68'(vc68[0]) * 68'sd4) +
				rvrm_pkg::rnd_shift(68'(vp_s68[2]), 27));
		end
	end

	for (genvar e = 0; e < NE; e++) begin : g_smpack
		assign sm_pack_s69[e*VW +: VW] = sm_s69[e];
	end

	// stage 70: (1 - cos) * Ku*Ku
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				okk_s70[i] <= $signed(omc_s69) * kk_s69[i];
			end
			for (int c = 0; c < NC; c++) begin
				ssu_s70[c] <= ssu_s69[c];
			end
			sm_s70 <= sm_pack_s69;
		end
	end

	// stage 71: assemble, saturate, pick branch
	always_ff @(posedge clk) begin
		if (adv) begin
			if (small_s70) begin
				res_s71 <= sm_s70;
			end else begin
				res_s71[0*VW +: VW] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 +
					rvrm_pkg::rnd_shift(okk_s70[0], 30));
				res_s71[4*VW +: VW] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 +
					rvrm_pkg::rnd_shift(okk_s70[1], 30));
				res_s71[8*VW +: VW] <= rvrm_pkg::sat32(rvrm_pkg::ONE_Q30 +
					rvrm_pkg::rnd_shift(okk_s70[2], 30));
				res_s71[1*VW +: VW] <= rvrm_pkg::sat32(-68'(ssu_s70[2]) +
					rvrm_pkg::rnd_shift(okk_s70[3], 30));
				res_s71[3*VW +: VW] <= rvrm_pkg::sat32(68'(ssu_s70[2]) +
					rvrm_pkg::rnd_shift(okk_s70[3], 30));
				res_s71[2*VW +: VW] <= rvrm_pkg::sat32(68'(ssu_s70[1]) +
					rvrm_pkg::rnd_shift(okk_s70[4], 30));
				res_s71[6*VW +: VW] <= rvrm_pkg::sat32(-68'(ssu_s70[1]) +
					rvrm_pkg::rnd_shift(okk_s70[4], 30));
				res_s71[5*VW +: VW] <= rvrm_pkg::sat32(-68'(ssu_s70[0]) +
					rvrm_pkg::rnd_shift(okk_s70[5], 30));
				res_s71[7*VW +: VW] <= rvrm_pkg::sat32(68'(ssu_s70[0]) +
					rvrm_pkg::rnd_shift(okk_s70[5], 30));
			end
		end
	end

	// output register with skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_tready) begin
			out_v_q <= vld_q[LAT-1];
		end else if (vld_q[LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_d_q <= skid_d_q;
			end
		end else if (!out_v_q || m_tready) begin
			out_d_q <= res_s71;
		end else begin
			skid_d_q <= res_s71;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

endmodule
`default_nettype wire

>>> hw/rtl/rvrm_checker.sv
// Port-level checks for the rotation vector to matrix unit, bound to the top level.
`default_nettype none
module rvrm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         psel,
	input wire logic         penable,
	input wire logic         pwrite,
	input wire logic [2:0]   paddr,
	input wire logic [31:0]  pwdata,
	input wire logic [31:0]  prdata,
	input wire logic         pready,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [287:0] m_tdata
);

	// stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// stalled word stays unchanged
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed while stalled");

	// input closes only after the output was held off
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> ($past(m_tvalid) && !$past(m_tready)))
		else $error("s_tready low without output stall");

	// threshold reads back what was written
	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == {rvrm_pkg::REG_THRESH, 2'b00})
		##1 (paddr == {rvrm_pkg::REG_THRESH, 2'b00})
		|-> (prdata == {3'b0, $past(pwdata[28:0])}))
		else $error("threshold readback mismatch");

endmodule

bind rotation_vector_to_rotation_matrix_unit rvrm_checker u_chk (.*);
`default_nettype wire

>>> test/tb.sv
// Testbench for the rotation vector to rotation matrix unit: streams vectors, checks each matrix.
`default_nettype none
module tb;

	typedef struct {
		logic signed [31:0] v [3];
	} rotvec_t;

	typedef struct {
		logic [31:0] m [9];
	} rotmat_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;   // rot_x, rot_y, rot_z
	logic         m_tvalid;
	logic         m_tready;
	logic [287:0] m_tdata;   // m00, m01, m02, m10, m11, m12, m20, m21, m22

	rotation_vector_to_rotation_matrix_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	localparam longint Q30   = 64'sd1073741824;
	localparam longint PI30  = 64'sd3373259426;
	localparam longint HPI30 = 64'sd1686629713;
	localparam longint TPI30 = 64'sd6746518852;
	localparam longint LIMIT = 64'd2000000;

	rotvec_t     vec_q [$];
	rotmat_t     mat_q [$];
	logic [28:0] thresh;
	int          fails;
	int          n_sent;
	int          n_got;
	longint      cyc;
	logic        hold;
	int          burst;
	int          gap;
	int          stall_ph;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// n / d rounded to nearest, ties away from zero
	function automatic longint rdiv(longint n, longint d);
		longint q;
		q = ((n < 0 ? -n : n) + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic logic [31:0] clamp32(longint x);
		if (x > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (x < -64'sd2147483648)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	function automatic longint root64(logic [63:0] n);
		logic [63:0] rem, res, b;
		rem = n;
		res = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	// skew matrix entry (i,j) of w
	function automatic longint skew(longint w [3], int i, int j);
		case (i * 3 + j)
			1: return -w[2];
			2: return w[1];
			3: return w[2];
			5: return -w[0];
			6: return -w[1];
			7: return w[0];
			default: return 0;
		endcase
	endfunction

	// expected rotation matrix for one vector
	function automatic rotmat_t rodrigues(rotvec_t x);
		rotmat_t r;
		longint v [3];
		longint u [3];
		longint th, t, a, b, rr, r2, sn, cs, omc, kk, e, sq;
		bit flip;
		for (int i = 0; i < 3; i++)
			v[i] = x.v[i];
		th = root64(64'(v[0] * v[0]) + 64'(v[1] * v[1]) + 64'(v[2] * v[2]));
		if (th < longint'(thresh)) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					if (i == j) begin
						a = v[(i + 1) % 3];
						b = v[(i + 2) % 3];
						sq = a * a + b * b;
						e = Q30 - ((sq + (64'sd1 << 26)) >>> 27);
					end else begin
						e = 4 * skew(v, i, j) + rdiv(v[i] * v[j], 64'sd1 << 27);
					end
					r.m[i * 3 + j] = clamp32(e);
				end
			return r;
		end
		for (int i = 0; i < 3; i++)
			u[i] = (th == 0) ? 0 : rdiv(v[i] * Q30, th);
		// angle reduction and folding
		t = (th * 4) % TPI30;
		if (t > PI30)
			t -= TPI30;
		flip = 1'b1;
		if (t > HPI30)
			rr = PI30 - t;
		else if (t < -HPI30)
			rr = -PI30 - t;
		else begin
			rr = t;
			flip = 1'b0;
		end
		r2 = rdiv(rr * rr, Q30);
		a = Q30;
		for (int k = 7; k >= 1; k--)
			a = Q30 - rdiv(r2 * a, longint'(2 * k * (2 * k + 1)) * Q30);
		cs = Q30;
		for (int k = 8; k >= 1; k--)
			cs = Q30 - rdiv(r2 * cs, longint'((2 * k - 1) * 2 * k) * Q30);
		sn = rdiv(rr * a, Q30);
		if (flip)
			cs = -cs;
		omc = Q30 - cs;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				if (i == j) begin
					a = u[(i + 1) % 3];
					b = u[(i + 2) % 3];
					kk = rdiv(-(a * a + b * b), Q30);
					e = Q30;
				end else begin
					kk = rdiv(u[i] * u[j], Q30);
					e = rdiv(sn * skew(u, i, j), Q30);
				end
				e += rdiv(omc * kk, Q30);
				r.m[i * 3 + j] = clamp32(e);
			end
		return r;
	endfunction

	// component with a random magnitude class
	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			2, 3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			4, 5: return 32'($signed($urandom_range(0, 200000)) - 100000);
			default: return 32'($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
		endcase
	endfunction

	task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		rotvec_t r;
		r.v[0] = x;
		r.v[1] = y;
		r.v[2] = z;
		vec_q.push_back(r);
	endtask

	task automatic apb_write(logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {rvrm_pkg::REG_THRESH, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thresh = d[28:0];
	endtask

	// wait until the pipeline is empty
	task automatic drain();
		wait (vec_q.size() == 0 && !s_tvalid && mat_q.size() == 0);
		repeat (rvrm_pkg::PIPE_LAT + 10) @(posedge clk);
	endtask

	// sender: bursts and gaps; the head of vec_q is the word on s_tdata
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst <= 0;
			gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				mat_q.push_back(rodrigues(vec_q[0]));
				void'(vec_q.pop_front());
				n_sent++;
			end
			if (gap > 0) begin
				gap <= gap - 1;
				s_tvalid <= 1'b0;
			end else if (vec_q.size() > 0 && !hold) begin
				s_tvalid <= 1'b1;
				s_tdata <= {vec_q[0].v[2], vec_q[0].v[1], vec_q[0].v[0]};
				if (burst <= 0) begin
					burst <= $urandom_range(1, 40);
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst <= burst - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_ph <= 0;
		end else begin
			stall_ph <= stall_ph + 1;
			if (stall_ph % 1024 < 300)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) < 30 + (stall_ph / 1024) % 4 * 20);
			if (m_tvalid && m_tready) begin
				n_got++;
				if (mat_q.size() == 0) begin
					$error("matrix word with no vector pending");
					fails++;
				end else begin
					for (int i = 0; i < 9; i++)
						if (m_tdata[32 * i +: 32] !== mat_q[0].m[i]) begin
							$error("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
								$signed(mat_q[0].m[i]), $signed(m_tdata[32 * i +: 32]));
							fails++;
						end
					void'(mat_q.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [31:0] th_set [4];
		logic [31:0] c;
		th_set = '{32'd0, 32'h1fff_ffff, 32'd268435456, 32'd1000};
		fails = 0;
		n_sent = 0;
		n_got = 0;
		cyc = 0;
		hold = 1'b0;
		thresh = 29'd268;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reset threshold, small angles, extremes, each axis
		add_vec(0, 0, 0);
		add_vec(100, -50, 7);
		add_vec(267, 0, 0);
		add_vec(268, 0, 0);
		add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_vec(32'h7fff_ffff, 0, 0);
		add_vec(0, 32'h8000_0000, 0);
		add_vec(0, 0, 32'd421657428);
		add_vec(32'd843314857, 0, 0);
		add_vec(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
		add_vec(32'd268435456, 32'hf000_0000, 32'd123456789);
		drain();
		// threshold sweep; zero, maximum, a mid value and a small one
		for (int p = 0; p < 4; p++) begin
			apb_write(th_set[p]);
			if (p == 0)
				add_vec(0, 0, 0);
			add_vec(32'h8000_0000, 0, 32'h7fff_ffff);
			add_vec(999, -999, 1);
			for (int n = 0; n < 480; n++) begin
				c = rnd_comp();
				add_vec(c, rnd_comp(), rnd_comp());
			end
			// one pause until every matrix has come
			wait (vec_q.size() < 240);
			hold = 1'b1;
			wait (mat_q.size() == 0 && !s_tvalid);
			hold = 1'b0;
			drain();
		end
		$display("sent %0d rotation vectors, checked %0d matrices over several thresholds",
			n_sent, n_got);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
